FILE: rtl/bfcr_pkg.sv
// -----------------------------------------------------------------------------
// bfcr_pkg: shared types and constants for the 4x7 bitmap font renderer
// Word layouts for both channels, the font table and the command bytes.
// -----------------------------------------------------------------------------
package bfcr_pkg;

  localparam int PanelWidthDefault  = 96;
  localparam int PanelHeightDefault = 64;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] CMD_COLUMN_RANGE = 8'h15;
  localparam logic [7:0] CMD_ROW_RANGE    = 8'h75;

  localparam int GlyphBits = 28;
  localparam int SeqCntW   = 5;

  // Configuration register indexes.
  localparam logic [1:0] REG_FOREGROUND = 2'd0;
  localparam logic [1:0] REG_BACKGROUND = 2'd1;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } result_t;

  typedef struct packed {
    logic                 hit;
    logic [GlyphBits-1:0] glyph;
  } font_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_GLYPH,
    ST_PAD,
    ST_SPARE
  } seq_state_t;

  function automatic font_t font_lookup(input logic [7:0] code);
    font_t f;
    f.hit = 1'b1;
    unique case (code)
      8'h30:        f.glyph = 28'hF99999F;
      8'h31:        f.glyph = 28'h2222222;
      8'h32:        f.glyph = 28'hF11F88F;
      8'h33:        f.glyph = 28'hF11711F;
      8'h34:        f.glyph = 28'h199F111;
      8'h35:        f.glyph = 28'hF88F11F;
      8'h36:        f.glyph = 28'hF88F99F;
      8'h37:        f.glyph = 28'hF111111;
      8'h38:        f.glyph = 28'hF99F99F;
      8'h39:        f.glyph = 28'hF99F11F;
      8'h41, 8'h61: f.glyph = 28'h699F999;
      8'h42, 8'h62: f.glyph = 28'hE9AEA9E;
      8'h43, 8'h63: f.glyph = 28'h6988896;
      8'h44, 8'h64: f.glyph = 28'hCA999AC;
      8'h45, 8'h65: f.glyph = 28'hF88E88F;
      8'h46, 8'h66: f.glyph = 28'hF88E888;
      8'h2D:        f.glyph = 28'h0007000;
      8'h3A:        f.glyph = 28'h0002002;
      8'h2E:        f.glyph = 28'h0000002;
      8'h2F:        f.glyph = 28'h1224488;
      8'h20:        f.glyph = 28'h0000000;
      default: begin
        f.hit   = 1'b0;
        f.glyph = '0;
      end
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/bitmap_font_char_renderer_core.sv
// -----------------------------------------------------------------------------
// bitmap_font_char_renderer_core: 4x7 font character renderer
// Turns (column, row, code) into a window command and its pixel stream.
// -----------------------------------------------------------------------------
//
//  channel  signals                          direction  word
//  -------  -------------------------------  ---------  ---------------------
//  item     item_valid, item_stall, item     in         column, row, code
//  result   result_valid, result_stall,      out        is_data, value, last
//           result
//  cfg      cfg_valid, cfg_ready,            in         register write
//           cfg_index, cfg_data
//
//  A drawable character is 34 to 46 result words, one per cycle while the
//  result is not stalled; an unknown code or an off-panel cell gives no words.
//  The result port emits one word per cycle unless the result is stalled.
//  Items land in a four-entry queue memory with a registered read port, so
//  new items are taken while a character is still being sent.
//  Reset empties the queue, idles the sequencer, clears the output valid and
//  sets the colours. A stalled result holds in the output register; items
//  stall only when the queue is full.

module bitmap_font_char_renderer_core #(
  parameter int PANEL_WIDTH  = bfcr_pkg::PanelWidthDefault,
  parameter int PANEL_HEIGHT = bfcr_pkg::PanelHeightDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bfcr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bfcr_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import bfcr_pkg::*;

  localparam logic [8:0] ColLimit = 9'(PANEL_WIDTH - 4);
  localparam logic [8:0] RowLimit = 9'(PANEL_HEIGHT - 7);

  // Colour registers.
  logic [7:0] foreground_color;
  logic [7:0] background_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      foreground_color <= 8'hFF;
      background_color <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FOREGROUND) begin
        foreground_color <= cfg_data;
      end else if (cfg_index == REG_BACKGROUND) begin
        background_color <= cfg_data;
      end
    end
  end

  // Item queue memory.
  item_t               fifo_mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCntW-1:0] fill;
  logic                push;
  logic                pop;
  item_t               fetch;
  logic                fetch_valid;
  logic                load;

  assign item_stall = (fill == FifoCntW'(FifoDepth));
  assign push       = item_valid && !item_stall;
  assign pop        = (fill != '0) && (!fetch_valid || load);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= item;
    end
    if (pop) begin
      fetch <= fifo_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fill        <= '0;
      fetch_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + FifoCntW'(push) - FifoCntW'(pop);
      if (pop) begin
        fetch_valid <= 1'b1;
      end else if (load) begin
        fetch_valid <= 1'b0;
      end
    end
  end

  // Decode of the fetched word.
  font_t font;
  logic  job_ok;
  logic  new_pad;
  logic  new_lead;

  assign font     = font_lookup(fetch.char_code);
  assign new_pad  = {1'b0, fetch.column} < ColLimit;
  assign new_lead = {1'b0, fetch.row} < RowLimit;
  assign job_ok   = font.hit && ({1'b0, fetch.column} <= ColLimit)
                    && ({1'b0, fetch.row} <= RowLimit);

  // Current character.
  logic [GlyphBits-1:0] glyph;
  logic [7:0]           left;
  logic [7:0]           upper;
  logic                 pad;
  logic                 lead;

  always_ff @(posedge clk) begin
    if (load) begin
      glyph <= font.glyph;
      left  <= fetch.column;
      upper <= fetch.row;
      pad   <= new_pad;
      lead  <= new_lead;
    end
  end

  // Word sequencer.
  seq_state_t         state;
  seq_state_t         state_next;
  logic [SeqCntW-1:0] cnt;
  logic [SeqCntW-1:0] cnt_next;
  logic               adv;
  logic               emit;
  result_t            word;
  logic [SeqCntW-1:0] spare_start;

  assign adv         = !result_valid || !result_stall;
  assign emit        = (state != ST_IDLE) && adv;
  assign spare_start = pad ? SeqCntW'(4) : SeqCntW'(3);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    word.is_data = 1'b1;
    word.value   = background_color;
    word.last    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        word.is_data = 1'b0;
      end
      ST_CMD: begin
        word.is_data = 1'b0;
        unique case (cnt)
          SeqCntW'(0): word.value = CMD_COLUMN_RANGE;
          SeqCntW'(1): word.value = left;
          SeqCntW'(2): word.value = left + (pad ? 8'd4 : 8'd3);
          SeqCntW'(3): word.value = CMD_ROW_RANGE;
          SeqCntW'(4): word.value = upper;
          default:     word.value = upper + (lead ? 8'd7 : 8'd6);
        endcase
        if (cnt >= SeqCntW'(5)) begin
          state_next = ST_GLYPH;
          cnt_next   = SeqCntW'(GlyphBits - 1);
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_GLYPH: begin
        word.value = glyph[cnt] ? foreground_color : background_color;
        if (pad && (cnt[1:0] == 2'd0)) begin
          state_next = ST_PAD;
        end else if (cnt == '0) begin
          if (lead) begin
            state_next = ST_SPARE;
            cnt_next   = spare_start;
          end else begin
            state_next = ST_IDLE;
            word.last  = 1'b1;
          end
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_PAD: begin
        // The pad pixel follows the fourth pixel of each glyph row.
        if (cnt == '0) begin
          if (lead) begin
            state_next = ST_SPARE;
            cnt_next   = spare_start;
          end else begin
            state_next = ST_IDLE;
            word.last  = 1'b1;
          end
        end else begin
          state_next = ST_GLYPH;
          cnt_next   = cnt - 1'b1;
        end
      end
      ST_SPARE: begin
        if (cnt == '0) begin
          state_next = ST_IDLE;
          word.last  = 1'b1;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (!emit) begin
      state_next = state;
      cnt_next   = cnt;
    end
    // A new character is taken when idle or as the last word of the current
    // one leaves.
    load = fetch_valid && ((state == ST_IDLE) || (emit && word.last));
    if (load) begin
      state_next = job_ok ? ST_CMD : ST_IDLE;
      cnt_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= word;
    end
  end

  // Checks.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FifoCntW'(FifoDepth))
    else $error("queue fill above its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0)
    else $error("queue read while empty");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load && job_ok |=> state == ST_CMD && cnt == '0)
    else $error("loaded character did not start at the window command");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    emit && word.last |=> state == ST_IDLE || state == ST_CMD)
    else $error("sequencer kept running after the last word");

endmodule

FILE: sim/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4x7 font character renderer
// Character cells go in on the item channel. Each accepted cell is rendered
// by a behavioural predictor into the expected window command and pixel
// words. Every word leaving the result channel is then compared with the
// oldest expected word. The colour registers are changed between phases,
// and the sender and receiver idle at random.
// -----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfcr_pkg::*;

  localparam int ColLimit    = PanelWidthDefault - 4;
  localparam int RowLimit    = PanelHeightDefault - 7;
  localparam int DrainCycles = 60;
  localparam int CycleLimit  = 400000;

  // Indexes with no register behind them; writes to these must be ignored.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  class glyph_scoreboard;
    logic [7:0] foreground;
    logic [7:0] background;
    result_t    expected_words[$];
    int         errors;
    int         checked;
    int         drawn;

    function new();
      foreground = 8'hFF;
      background = 8'h00;
    endfunction

    function void set_register(logic [1:0] index, logic [7:0] data);
      case (index)
        REG_FOREGROUND: foreground = data;
        REG_BACKGROUND: background = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("tb_top: mismatch: %s", msg);
    endtask

    function void push_word(logic is_data, logic [7:0] value);
      result_t w;
      w.is_data = is_data;
      w.value   = value;
      w.last    = 1'b0;
      expected_words.push_back(w);
    endfunction

    // Renders one accepted cell into the words the block should send.
    function void note_item(item_t it);
      logic [27:0] glyph;
      bit          known;
      bit          pad;
      bit          spare;
      int          w;
      int          h;
      known = 1'b1;
      case (it.char_code)
        8'h30: glyph = 28'hF99999F;
        8'h31: glyph = 28'h2222222;
        8'h32: glyph = 28'hF11F88F;
        8'h33: glyph = 28'hF11711F;
        8'h34: glyph = 28'h199F111;
        8'h35: glyph = 28'hF88F11F;
        8'h36: glyph = 28'hF88F99F;
        8'h37: glyph = 28'hF111111;
        8'h38: glyph = 28'hF99F99F;
        8'h39: glyph = 28'hF99F11F;
        8'h41, 8'h61: glyph = 28'h699F999;
        8'h42, 8'h62: glyph = 28'hE9AEA9E;
        8'h43, 8'h63: glyph = 28'h6988896;
        8'h44, 8'h64: glyph = 28'hCA999AC;
        8'h45, 8'h65: glyph = 28'hF88E88F;
        8'h46, 8'h66: glyph = 28'hF88E888;
        8'h2D: glyph = 28'h0007000;
        8'h3A: glyph = 28'h0002002;
        8'h2E: glyph = 28'h0000002;
        8'h2F: glyph = 28'h1224488;
        8'h20: glyph = 28'h0000000;
        default: begin
          glyph = '0;
          known = 1'b0;
        end
      endcase
      if (!known || it.column > ColLimit || it.row > RowLimit) return;
      drawn++;
      pad   = it.column < ColLimit;
      spare = it.row < RowLimit;
      w     = pad ? 5 : 4;
      h     = spare ? 8 : 7;
      push_word(1'b0, CMD_COLUMN_RANGE);
      push_word(1'b0, it.column);
      push_word(1'b0, 8'(it.column + w - 1));
      push_word(1'b0, CMD_ROW_RANGE);
      push_word(1'b0, it.row);
      push_word(1'b0, 8'(it.row + h - 1));
      for (int i = 27; i >= 0; i--) begin
        push_word(1'b1, glyph[i] ? foreground : background);
        if (pad && (i % 4) == 0) push_word(1'b1, background);
      end
      if (spare) begin
        for (int i = 0; i < w; i++) push_word(1'b1, background);
      end
      expected_words[$].last = 1'b1;
    endfunction

    task check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("word with nothing expected: is_data %0b value %02h last %0b",
                         got.is_data, got.value, got.last));
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (got.is_data !== want.is_data)
        report($sformatf("word %0d is_data %0b, expected %0b", checked, got.is_data,
                         want.is_data));
      if (got.value !== want.value)
        report($sformatf("word %0d value %02h, expected %02h", checked, got.value,
                         want.value));
      if (got.last !== want.last)
        report($sformatf("word %0d last %0b, expected %0b", checked, got.last, want.last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_t      item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_FOREGROUND;
  logic [7:0] cfg_data = '0;

  glyph_scoreboard sb = new();
  int send_idle_pct  = 26;
  int recv_stall_pct = 49;
  int items_sent;
  int reg_writes;
  int cycles;

  // Every code in the font, both cases of the hex letters.
  logic [7:0] font_codes[27] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
    8'h2D, 8'h3A, 8'h2E, 8'h2F, 8'h20
  };

  bitmap_font_char_renderer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_word(result);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: timed out with %0d words outstanding", sb.pending());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Called just after a rising edge; returns on the edge that takes the word.
  task automatic send_item(input logic [7:0] column, input logic [7:0] row,
                           input logic [7:0] code);
    item_t it;
    it.column    = column;
    it.row       = row;
    it.char_code = code;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(index, data);
    reg_writes++;
  endtask

  task automatic set_colours(input logic [7:0] fg, input logic [7:0] bg);
    write_reg(REG_FOREGROUND, fg);
    write_reg(REG_SPARE_A, 8'($urandom));
    write_reg(REG_BACKGROUND, bg);
    write_reg(REG_SPARE_B, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Mostly drawable cells with random content, some at the panel edges,
  // the rest off-panel cells and plain noise.
  task automatic send_random(input int count);
    int         pick;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] code;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      code = font_codes[$urandom_range(26)];
      if (pick < 80) begin
        column = (pick < 12) ? 8'(ColLimit - $urandom_range(1)) : 8'($urandom_range(ColLimit));
        row    = (pick >= 68) ? 8'(RowLimit - $urandom_range(1)) : 8'($urandom_range(RowLimit));
      end else if (pick < 88) begin
        column = (pick < 84) ? 8'($urandom_range(255, ColLimit + 1)) : 8'($urandom_range(ColLimit));
        row    = (pick < 84) ? 8'($urandom) : 8'($urandom_range(255, RowLimit + 1));
      end else begin
        column = 8'($urandom);
        row    = 8'($urandom);
        code   = 8'($urandom);
      end
      send_item(column, row, code);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cells under the reset colours.
    send_item(8'd0,  8'd0,  8'h30);
    send_item(8'd92, 8'd57, 8'h38);
    send_item(8'd91, 8'd56, 8'h42);
    send_item(8'd92, 8'd0,  8'h2F);
    send_item(8'd0,  8'd57, 8'h2D);
    send_item(8'd93, 8'd0,  8'h31);
    send_item(8'd0,  8'd58, 8'h31);
    send_item(8'hFF, 8'hFF, 8'h46);
    send_item(8'd10, 8'd10, 8'h00);
    send_item(8'd10, 8'd10, 8'hFF);
    send_item(8'd10, 8'd10, 8'h47);
    send_item(8'd5,  8'd5,  8'h61);
    send_item(8'd5,  8'd5,  8'h41);
    send_item(8'd20, 8'd30, 8'h3A);
    send_item(8'd20, 8'd30, 8'h2E);
    send_item(8'd20, 8'd30, 8'h20);
    send_item(8'd40, 8'd20, 8'h63);
    send_item(8'd41, 8'd21, 8'h44);
    send_item(8'd42, 8'd22, 8'h65);
    send_item(8'd43, 8'd23, 8'h66);
    send_item(8'd88, 8'd50, 8'h39);
    send_item(8'd1,  8'd1,  8'h37);
    send_item(8'd60, 8'd40, 8'h34);
    wait_idle();

    set_colours(8'h00, 8'hFF);
    send_random(75);
    wait_idle();

    send_idle_pct  = 49;
    recv_stall_pct = 26;
    set_colours(8'($urandom), 8'($urandom));
    send_random(75);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_colours(8'h5A, 8'hA5);
    send_random(75);
    wait_idle();

    $display("tb_top: %0d cells sent, %0d drawn, %0d words checked, %0d register writes",
             items_sent, sb.drawn, sb.checked, reg_writes);
    $display("tb_top: %0d mismatches over four colour settings and three idling patterns",
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
